// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tlik_pkg.sv
`timescale 1ns / 1ps

package tlik_pkg;

    // field widths
    localparam int LEN_W = 16;
    localparam int XY_W  = 18;
    localparam int SH_W  = 18;
    localparam int EL_W  = 16;
    localparam int IDX_W = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_FIRST_LINK  = 2'd0;
    localparam logic [IDX_W-1:0] REG_SECOND_LINK = 2'd1;
    localparam logic [LEN_W-1:0] LINK_RESET      = 16'd4096;

    // front end
    localparam int R2_W  = 36;
    localparam int NUM_W = 38;
    localparam int DEN_W = 33;
    localparam int MAG_W = 50;
    localparam int FRAC_C = 14;

    // cosine divider
    localparam int DIV_BITS = 15;
    localparam int Q_W      = DIV_BITS;
    localparam int C_W      = 16;
    localparam logic [Q_W-1:0]        Q_ONE = 15'd16384;
    localparam logic signed [C_W-1:0] C_ONE = 16'sd16384;

    // sine root
    localparam int SQ_IN_W  = 30;
    localparam int SQ_STEPS = 15;
    localparam int SQ_TOP   = 28;
    localparam int S_W      = 15;
    localparam logic [SQ_IN_W-1:0] SQ_ONE = 30'h1000_0000;

    // atan2
    localparam int K_W          = 34;
    localparam int SCALE        = 24;
    localparam int CORD_W       = 60;
    localparam int Z_W          = 35;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORD_STAGES  =
        (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam logic signed [Z_W-1:0] PI_Q30 = 35'sd3373259426;
    localparam logic signed [Z_W-1:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
        35'sd67021687,  35'sd33543516,  35'sd16775851,  35'sd8388437,
        35'sd4194283,   35'sd2097149,   35'sd1048576,   35'sd524288,
        35'sd262144,    35'sd131072,    35'sd65536,     35'sd32768,
        35'sd16384,     35'sd8192,      35'sd4096,      35'sd2048,
        35'sd1024,      35'sd512,       35'sd256,       35'sd128
    };

    // Q.30 to Q4.13 rounding
    localparam int DROP = 17;
    localparam logic signed [Z_W-1:0] ROUND_Q30 = 35'sd65536;

    // per-item info carried alongside the arithmetic pipes
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic                   up;
        logic                   unreach;
        logic                   neg;
        logic                   den_zero;
        logic signed [C_W-1:0]  c;
    } side_t;

endpackage

// File: hdl/tlik_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage, MSB first.
module tlik_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        valid,
    input  logic [tlik_pkg::MAG_W-1:0]  dividend,
    input  logic [tlik_pkg::DEN_W-1:0]  divisor,
    input  tlik_pkg::side_t             tag,
    output logic                        quo_valid,
    output logic [tlik_pkg::Q_W-1:0]    quotient,
    output tlik_pkg::side_t             quo_tag
);
    import tlik_pkg::*;

    logic [MAG_W-1:0] rem_reg [DIV_BITS];
    logic [Q_W-1:0]   q_reg   [DIV_BITS];
    side_t            tag_reg [DIV_BITS];
    logic             vld_reg [DIV_BITS];

    for (genvar i = 0; i < DIV_BITS; i++) begin : g_stage
        logic [MAG_W-1:0] rem_in;
        logic [MAG_W-1:0] sub;
        logic [Q_W-1:0]   q_in;
        side_t            t_in;
        logic             v_in;
        logic             ge;

        if (i == 0) begin : g_first
            assign rem_in = dividend;
            assign q_in   = '0;
            assign t_in   = tag;
            assign v_in   = valid;
        end
        else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign t_in   = tag_reg[i-1];
            assign v_in   = vld_reg[i-1];
        end

        assign sub = MAG_W'(divisor) << (DIV_BITS - 1 - i);
        assign ge  = rem_in >= sub;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? rem_in - sub : rem_in;
                q_reg[i]   <= {q_in[Q_W-2:0], ge};
                tag_reg[i] <= t_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= v_in;
            end
        end
    end

    assign quo_valid = vld_reg[DIV_BITS-1];
    assign quotient  = q_reg[DIV_BITS-1];
    assign quo_tag   = tag_reg[DIV_BITS-1];

endmodule

// File: hdl/tlik_sqrt.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Bitwise integer square root, one result bit per stage.
module tlik_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         valid,
    input  logic [tlik_pkg::SQ_IN_W-1:0] radicand,
    input  tlik_pkg::side_t              tag,
    output logic                         root_valid,
    output logic [tlik_pkg::S_W-1:0]     root,
    output tlik_pkg::side_t              root_tag
);
    import tlik_pkg::*;

    logic [SQ_IN_W-1:0] v_reg   [SQ_STEPS];
    logic [SQ_IN_W-1:0] r_reg   [SQ_STEPS];
    side_t              tag_reg [SQ_STEPS];
    logic               vld_reg [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
        localparam logic [SQ_IN_W-1:0] BIT = SQ_IN_W'(1) << (SQ_TOP - 2 * k);
        logic [SQ_IN_W-1:0] v_in;
        logic [SQ_IN_W-1:0] r_in;
        logic [SQ_IN_W-1:0] trial;
        side_t              t_in;
        logic               vl_in;
        logic               ge;

        if (k == 0) begin : g_first
            assign v_in  = radicand;
            assign r_in  = '0;
            assign t_in  = tag;
            assign vl_in = valid;
        end
        else begin : g_rest
            assign v_in  = v_reg[k-1];
            assign r_in  = r_reg[k-1];
            assign t_in  = tag_reg[k-1];
            assign vl_in = vld_reg[k-1];
        end

        assign trial = r_in + BIT;
        assign ge    = v_in >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k]   <= ge ? v_in - trial : v_in;
                r_reg[k]   <= ge ? (r_in >> 1) + BIT : r_in >> 1;
                tag_reg[k] <= t_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vl_in;
            end
        end
    end

    assign root_valid = vld_reg[SQ_STEPS-1];
    assign root       = r_reg[SQ_STEPS-1][S_W-1:0];
    assign root_tag   = tag_reg[SQ_STEPS-1];

    // radicand never exceeds 2^28, so the root never exceeds one in Q1.14
    `ASSERT_IMPLY(a_root_range, root_valid, r_reg[SQ_STEPS-1] <= SQ_IN_W'(Q_ONE), "root above one")

endmodule

// File: hdl/tlik_cordic.sv
`timescale 1ns / 1ps

// Vectoring CORDIC atan2, Q.30 angle; a pre-stage folds the left half-plane.
module tlik_cordic (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            valid,
    input  logic signed [tlik_pkg::K_W-1:0] op_y,
    input  logic signed [tlik_pkg::K_W-1:0] op_x,
    input  tlik_pkg::side_t                 tag,
    output logic                            angle_valid,
    output logic signed [tlik_pkg::Z_W-1:0] angle,
    output tlik_pkg::side_t                 angle_tag
);
    import tlik_pkg::*;

    localparam int PAD = CORD_W - K_W - SCALE;

    logic signed [CORD_W-1:0] x_reg    [CORD_STAGES+1];
    logic signed [CORD_W-1:0] y_reg    [CORD_STAGES+1];
    logic signed [Z_W-1:0]    z_reg    [CORD_STAGES+1];
    logic                     zero_reg [CORD_STAGES+1];
    side_t                    tag_reg  [CORD_STAGES+1];
    logic                     vld_reg  [CORD_STAGES+1];

    logic signed [CORD_W-1:0] xs;
    logic signed [CORD_W-1:0] ys;
    logic                     x_neg;

    assign xs    = $signed({{PAD{op_x[K_W-1]}}, op_x, {SCALE{1'b0}}});
    assign ys    = $signed({{PAD{op_y[K_W-1]}}, op_y, {SCALE{1'b0}}});
    assign x_neg = op_x[K_W-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_neg ? -xs : xs;
            y_reg[0]    <= x_neg ? -ys : ys;
            z_reg[0]    <= !x_neg ? '0 : (op_y[K_W-1] ? -PI_Q30 : PI_Q30);
            zero_reg[0] <= (op_x == '0) && (op_y == '0);
            tag_reg[0]  <= tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= valid;
        end
    end

    for (genvar i = 0; i < CORD_STAGES; i++) begin : g_stage
        logic signed [CORD_W-1:0] xsh;
        logic signed [CORD_W-1:0] ysh;
        logic                     y_pos;

        assign xsh   = x_reg[i] >>> i;
        assign ysh   = y_reg[i] >>> i;
        assign y_pos = !y_reg[i][CORD_W-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= y_pos ? x_reg[i] + ysh : x_reg[i] - ysh;
                y_reg[i+1]    <= y_pos ? y_reg[i] - xsh : y_reg[i] + xsh;
                z_reg[i+1]    <= y_pos ? z_reg[i] + ATAN_Q30[i] : z_reg[i] - ATAN_Q30[i];
                zero_reg[i+1] <= zero_reg[i];
                tag_reg[i+1]  <= tag_reg[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end
    end

    // atan2(0,0) is defined as zero
    assign angle       = zero_reg[CORD_STAGES] ? '0 : z_reg[CORD_STAGES];
    assign angle_valid = vld_reg[CORD_STAGES];
    assign angle_tag   = tag_reg[CORD_STAGES];

endmodule

// File: hdl/two_link_inverse_kinematics_top.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Two-link planar arm inverse kinematics. Takes one target word per clock while
// the pipeline is not frozen, and returns one angle word per target, in order, via
// 2 front-end stages (squares, reach test), a 15-stage cosine divider,
// 2 stages for the clamp and c^2, a 15-stage sine root, 1 stage for k1/k2,
// three parallel 17-stage atan2 CORDICs and the output register. The whole
// pipeline advances together; it freezes only while a finished word sits in
// the output register and result_ready is low. Link lengths are written
// through cfg_write_en/cfg_index/cfg_data and must only change while the
// pipeline holds no words.
module two_link_inverse_kinematics_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [tlik_pkg::IDX_W-1:0]       cfg_index,
    input  logic [tlik_pkg::LEN_W-1:0]       cfg_data,
    input  logic                             target_valid,
    output logic                             target_ready,
    input  logic signed [tlik_pkg::XY_W-1:0] target_x,
    input  logic signed [tlik_pkg::XY_W-1:0] target_y,
    input  logic                             elbow_pos,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic signed [tlik_pkg::SH_W-1:0] shoulder_angle,
    output logic signed [tlik_pkg::EL_W-1:0] elbow_angle,
    output logic                             status
);
    import tlik_pkg::*;

    localparam logic signed [EL_W-1:0] ELBOW_MAX = 16'sd25800;

    logic [LEN_W-1:0] l1_reg;
    logic [LEN_W-1:0] l2_reg;
    logic             stage_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_reg <= LINK_RESET;
            l2_reg <= LINK_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_FIRST_LINK:  l1_reg <= cfg_data;
                REG_SECOND_LINK: l2_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    logic result_valid_reg;
    assign stage_en     = !result_valid_reg || result_ready;
    assign target_ready = stage_en;

    // ---- stage 1: squares and link products
    logic signed [XY_W-1:0]  x1_reg, y1_reg;
    logic                    up1_reg, v1_reg;
    logic [R2_W-1:0]         r2_reg;
    logic [2*LEN_W+1:0]      sumsq_reg;
    logic [2*LEN_W-1:0]      difsq_reg, l1sq_reg, l2sq_reg, l1l2_reg;

    logic signed [2*XY_W-1:0] xx, yy;
    logic [LEN_W:0]           lsum;
    logic [LEN_W-1:0]         ldif;

    assign xx   = target_x * target_x;
    assign yy   = target_y * target_y;
    assign lsum = {1'b0, l1_reg} + {1'b0, l2_reg};
    assign ldif = (l1_reg > l2_reg) ? l1_reg - l2_reg : l2_reg - l1_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en)
        begin
            x1_reg    <= target_x;
            y1_reg    <= target_y;
            up1_reg   <= elbow_pos;
            r2_reg    <= R2_W'($unsigned(xx)) + R2_W'($unsigned(yy));
            sumsq_reg <= lsum * lsum;
            difsq_reg <= ldif * ldif;
            l1sq_reg  <= l1_reg * l1_reg;
            l2sq_reg  <= l2_reg * l2_reg;
            l1l2_reg  <= l1_reg * l2_reg;
        end
    end

    // ---- stage 2: reach test and cosine numerator
    logic                    v2_reg;
    logic [MAG_W-1:0]        mag2_reg;
    logic [DEN_W-1:0]        den2_reg;
    side_t                   side2_reg;

    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0]        num_abs;
    side_t                   side2;

    assign num = $signed({2'b0, r2_reg}) - $signed({6'b0, l1sq_reg})
               - $signed({6'b0, l2sq_reg});
    assign num_abs = num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);

    always_comb
    begin
        side2          = '0;
        side2.x        = x1_reg;
        side2.y        = y1_reg;
        side2.up       = up1_reg;
        side2.unreach  = (r2_reg > R2_W'(sumsq_reg)) || (r2_reg < R2_W'(difsq_reg));
        side2.neg      = num[NUM_W-1];
        side2.den_zero = (l1l2_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en)
        begin
            mag2_reg  <= MAG_W'(num_abs[R2_W-1:0]) << FRAC_C;
            den2_reg  <= {l1l2_reg, 1'b0};
            side2_reg <= side2;
        end
    end

    // ---- cosine divider
    logic           div_valid;
    logic [Q_W-1:0] div_q;
    side_t          div_tag;

    tlik_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (stage_en),
        .valid     (v2_reg),
        .dividend  (mag2_reg),
        .divisor   (den2_reg),
        .tag       (side2_reg),
        .quo_valid (div_valid),
        .quotient  (div_q),
        .quo_tag   (div_tag)
    );

    // ---- stage 3: clamp and sign
    logic           v3_reg;
    side_t          side3_reg;
    logic [Q_W-1:0] qc;
    side_t          side3;

    assign qc = (div_q > Q_ONE) ? Q_ONE : div_q;

    always_comb
    begin
        side3 = div_tag;
        if (div_tag.den_zero)
        begin
            side3.c = C_ONE;
        end
        else if (div_tag.neg)
        begin
            side3.c = -$signed({1'b0, qc});
        end
        else
        begin
            side3.c = $signed({1'b0, qc});
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en)
        begin
            side3_reg <= side3;
        end
    end

    // ---- stage 4: 1 - c^2
    logic                   v4_reg;
    side_t                  side4_reg;
    logic [SQ_IN_W-1:0]     rad4_reg;
    logic signed [2*C_W-1:0] csq;

    assign csq = side3_reg.c * side3_reg.c;

    always_ff @(posedge clk)
    begin
        if (stage_en)
        begin
            side4_reg <= side3_reg;
            rad4_reg  <= SQ_ONE - SQ_IN_W'($unsigned(csq));
        end
    end

    // ---- sine root
    logic           sq_valid;
    logic [S_W-1:0] sq_root;
    side_t          sq_tag;

    tlik_sqrt u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (stage_en),
        .valid      (v4_reg),
        .radicand   (rad4_reg),
        .tag        (side4_reg),
        .root_valid (sq_valid),
        .root       (sq_root),
        .root_tag   (sq_tag)
    );

    // ---- stage 5: k1, k2
    logic                   v5_reg;
    side_t                  side5_reg;
    logic signed [K_W-1:0]  k1_reg, k2_reg, s5_reg;

    logic signed [C_W-1:0]     s_pos, s_sgn;
    logic signed [LEN_W+C_W:0] l2c, l2s;

    assign s_pos = $signed({1'b0, sq_root});
    assign s_sgn = sq_tag.up ? s_pos : -s_pos;
    assign l2c   = $signed({1'b0, l2_reg}) * sq_tag.c;
    assign l2s   = $signed({1'b0, l2_reg}) * s_sgn;

    always_ff @(posedge clk)
    begin
        if (stage_en)
        begin
            side5_reg <= sq_tag;
            s5_reg    <= K_W'(s_pos);
            k1_reg    <= $signed(K_W'({l1_reg, 14'b0})) + K_W'(l2c);
            k2_reg    <= K_W'(l2s);
        end
    end

    // ---- three atan2 units in parallel
    logic signed [Z_W-1:0] za, zb, zc;
    logic                  cord_valid;
    side_t                 cord_tag;

    tlik_cordic u_atan_target (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (stage_en),
        .valid       (v5_reg),
        .op_y        (K_W'(side5_reg.y)),
        .op_x        (K_W'(side5_reg.x)),
        .tag         ('0),
        .angle_valid (),
        .angle       (za),
        .angle_tag   ()
    );

    tlik_cordic u_atan_k (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (stage_en),
        .valid       (v5_reg),
        .op_y        (k2_reg),
        .op_x        (k1_reg),
        .tag         ('0),
        .angle_valid (),
        .angle       (zb),
        .angle_tag   ()
    );

    tlik_cordic u_atan_elbow (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (stage_en),
        .valid       (v5_reg),
        .op_y        (s5_reg),
        .op_x        (K_W'(side5_reg.c)),
        .tag         (side5_reg),
        .angle_valid (cord_valid),
        .angle       (zc),
        .angle_tag   (cord_tag)
    );

    // ---- output register
    logic signed [SH_W-1:0] shoulder_angle_reg;
    logic signed [EL_W-1:0] elbow_angle_reg;
    logic                   status_reg;

    logic signed [Z_W:0]   t1_sum;
    logic signed [Z_W-1:0] zc_sgn, t2_sum;

    assign t1_sum = (Z_W+1)'(za) - (Z_W+1)'(zb) + (Z_W+1)'(ROUND_Q30);
    assign zc_sgn = cord_tag.up ? zc : -zc;
    assign t2_sum = zc_sgn + ROUND_Q30;

    always_ff @(posedge clk)
    begin
        if (stage_en)
        begin
            status_reg <= cord_tag.unreach;
            if (cord_tag.unreach)
            begin
                shoulder_angle_reg <= '0;
                elbow_angle_reg    <= '0;
            end
            else
            begin
                shoulder_angle_reg <= t1_sum[SH_W+DROP-1:DROP];
                elbow_angle_reg    <= t2_sum[EL_W+DROP-1:DROP];
            end
        end
    end

    // valid bits travel with the words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
            v5_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (stage_en)
        begin
            v1_reg           <= target_valid;
            v2_reg           <= v1_reg;
            v3_reg           <= div_valid;
            v4_reg           <= v3_reg;
            v5_reg           <= sq_valid;
            result_valid_reg <= cord_valid;
        end
    end

    assign result_valid   = result_valid_reg;
    assign shoulder_angle = shoulder_angle_reg;
    assign elbow_angle    = elbow_angle_reg;
    assign status         = status_reg;

    `ASSERT_IMPLY(a_unreach_zero, result_valid_reg && status_reg, shoulder_angle_reg == '0 && elbow_angle_reg == '0, "unreachable word carries nonzero angle")
    `ASSERT_IMPLY(a_elbow_range, result_valid_reg && !status_reg, elbow_angle_reg <= ELBOW_MAX && elbow_angle_reg >= -ELBOW_MAX, "elbow angle beyond pi")

endmodule
